>>> src/dpbp_pkg.sv
// Shared types and constants for the depth pixel back-projection core.
// Used by every module of the block and by its port checker.
`default_nettype none

package dpbp_pkg;

  localparam int COORD_W = 12;
  localparam int DEPTH_W = 24;
  localparam int FOCAL_W = 16;
  localparam int MAG_W = 16;
  localparam int NUM_W = 40;
  localparam int DIVD_W = 41;
  localparam int Q_W = 32;
  localparam int DIV_STEP = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEP;

  // Stage positions along the pipeline.
  localparam int ST_IN = 0;
  localparam int ST_DIFF = 1;
  localparam int ST_MUL = 2;
  localparam int ST_ADD = 3;
  localparam int ST_DIV0 = 4;
  localparam int ST_OUT = ST_DIV0 + DIV_STAGES;
  localparam int PIPE_STAGES = ST_OUT + 1;

  localparam logic [Q_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] COORD_MIN = 32'h8000_0000;

  localparam logic [15:0] CENTER_X_RST = 16'd5112;
  localparam logic [15:0] CENTER_Y_RST = 16'd3832;
  localparam logic [15:0] FOCAL_X_RST = 16'd8400;
  localparam logic [15:0] FOCAL_Y_RST = 16'd8400;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_FOCAL_X    = 3'd2,
    REG_FOCAL_Y    = 3'd3,
    REG_RGB_ENABLE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [23:0] depth;
    logic        depth_invalid;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        color_present;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [23:0]        point_z;
    logic [7:0]         point_blue;
    logic [7:0]         point_green;
    logic [7:0]         point_red;
    logic               color_valid;
  } out_item_t;

  // Data that rides alongside the arithmetic unchanged.
  typedef struct packed {
    logic [23:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        color_valid;
  } side_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } axis_flags_t;

  typedef logic [PIPE_STAGES-1:0] stage_en_t;

  // Applies sign and saturation to a rounded quotient magnitude.
  function automatic logic [Q_W-1:0] sat_coord(input logic [Q_W-1:0] q,
                                               input axis_flags_t fl);
    logic [Q_W-1:0] res;
    if (fl.zero) begin
      res = '0;
    end else if (fl.neg) begin
      if (fl.ovf || (q[Q_W-1] && (q[Q_W-2:0] != '0))) begin
        res = COORD_MIN;
      end else begin
        res = (~q) + 32'd1;
      end
    end else begin
      if (fl.ovf || q[Q_W-1]) begin
        res = COORD_MAX;
      end else begin
        res = q;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/depth_pixel_back_projection_core.sv
// Throughput: one request per cycle while the output is not stalled; the
// 8-stage radix-16 divider per axis sets the depth. Dropped pixels leave a
// bubble that later requests fill.
// Reset clears all valid bits and loads the default intrinsics; rgb is off.
// Depends on dpbp_pkg, dpbp_ctrl and dpbp_axis.
`default_nettype none

module depth_pixel_back_projection_core #(
  parameter int COORD_BITS = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dpbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output dpbp_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire [2:0]           cfg_index,
  input  wire [15:0]          cfg_data
);
  import dpbp_pkg::*;

  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 1);

  logic [15:0] center_x_r;
  logic [15:0] center_y_r;
  logic [15:0] focal_x_r;
  logic [15:0] focal_y_r;
  logic        rgb_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      focal_x_r <= FOCAL_X_RST;
      focal_y_r <= FOCAL_Y_RST;
      rgb_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   center_x_r <= cfg_data;
        REG_CENTER_Y:   center_y_r <= cfg_data;
        REG_FOCAL_X:    focal_x_r <= cfg_data;
        REG_FOCAL_Y:    focal_y_r <= cfg_data;
        REG_RGB_ENABLE: rgb_enable_r <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  stage_en_t stage_en;
  logic      in_keep;

  // Invalid or zero-depth pixels never get a valid bit.
  assign in_keep = !in_data.depth_invalid && (in_data.depth != '0);

  dpbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_keep   (in_keep),
    .out_stall (out_stall),
    .stage_en  (stage_en),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  side_t              side_r [ST_OUT];
  logic               cv;

  assign cv = rgb_enable_r && in_data.color_present;

  always_ff @(posedge clk) begin
    if (stage_en[ST_IN]) begin
      col_r <= in_data.column & COORD_MASK;
      row_r <= in_data.row & COORD_MASK;
      side_r[ST_IN] <= '{depth: in_data.depth,
                         blue: cv ? in_data.blue : 8'd0,
                         green: cv ? in_data.green : 8'd0,
                         red: cv ? in_data.red : 8'd0,
                         color_valid: cv};
    end
    for (int k = ST_IN + 1; k < ST_OUT; k++) begin
      if (stage_en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [Q_W-1:0] qx;
  logic [Q_W-1:0] qy;
  axis_flags_t    flx;
  axis_flags_t    fly;

  dpbp_axis u_axis_x (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (col_r),
    .center   (center_x_r),
    .focal    (focal_x_r),
    .depth    (side_r[ST_IN].depth),
    .quot     (qx),
    .flags    (flx)
  );

  dpbp_axis u_axis_y (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (row_r),
    .center   (center_y_r),
    .focal    (focal_y_r),
    .depth    (side_r[ST_IN].depth),
    .quot     (qy),
    .flags    (fly)
  );

  out_item_t out_data_r;
  side_t     side_last;

  assign side_last = side_r[ST_OUT-1];

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      out_data_r.point_x <= sat_coord(qx, flx);
      out_data_r.point_y <= sat_coord(qy, fly);
      out_data_r.point_z <= side_last.depth;
      out_data_r.point_blue <= side_last.blue;
      out_data_r.point_green <= side_last.green;
      out_data_r.point_red <= side_last.red;
      out_data_r.color_valid <= side_last.color_valid;
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> src/dpbp_ctrl.sv
// Valid bits and per-stage load enables for the back-projection pipeline.
// A stage loads when it is empty or the stage after it moves. Uses dpbp_pkg.
`default_nettype none

module dpbp_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_keep,
  input  wire                   out_stall,
  output dpbp_pkg::stage_en_t   stage_en,
  output logic                  in_stall,
  output logic                  out_valid
);
  import dpbp_pkg::*;

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;

  // Bubbles collapse: an empty stage takes new data even when the output waits.
  always_comb begin
    stage_en[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (stage_en[0]) begin
      v_nxt[0] = in_valid && in_keep;
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (stage_en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !stage_en[0];
  assign out_valid = v_r[PIPE_STAGES-1];

endmodule

`default_nettype wire

>>> src/dpbp_axis.sv
// One coordinate axis: offset from the principal point, scale by depth,
// then a pipelined rounding division by the focal length. Uses dpbp_pkg.
`default_nettype none

module dpbp_axis (
  input  wire                            clk,
  input  dpbp_pkg::stage_en_t            stage_en,
  input  wire [dpbp_pkg::COORD_W-1:0]    coord,
  input  wire [15:0]                     center,
  input  wire [dpbp_pkg::FOCAL_W-1:0]    focal,
  input  wire [dpbp_pkg::DEPTH_W-1:0]    depth,
  output logic [dpbp_pkg::Q_W-1:0]       quot,
  output dpbp_pkg::axis_flags_t          flags
);
  import dpbp_pkg::*;

  logic [16:0] diff;
  logic [16:0] diff_neg;
  logic [MAG_W-1:0] mag_r;
  logic             neg1_r;
  logic [DEPTH_W-1:0] depth1_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] num_nxt;
  logic             neg2_r;
  logic             zero2_r;
  logic [DIVD_W-1:0] d_r;
  logic [DIVD_W-1:0] d_nxt;
  logic              neg3_r;
  logic              zero3_r;

  // Coordinate is an integer pixel; scale to Q.4 before subtracting.
  assign diff = {1'b0, coord, 4'b0000} - {1'b0, center};
  assign diff_neg = (~diff) + 17'd1;

  always_ff @(posedge clk) begin
    if (stage_en[ST_DIFF]) begin
      neg1_r <= diff[16];
      mag_r <= diff[16] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
      depth1_r <= depth;
    end
  end

  assign num_nxt = NUM_W'(mag_r) * NUM_W'(depth1_r);

  always_ff @(posedge clk) begin
    if (stage_en[ST_MUL]) begin
      num_r <= num_nxt;
      neg2_r <= neg1_r;
      zero2_r <= (mag_r == '0);
    end
  end

  // Half the divisor is added up front so the truncating divide rounds.
  assign d_nxt = DIVD_W'(num_r) + DIVD_W'(focal >> 1);

  always_ff @(posedge clk) begin
    if (stage_en[ST_ADD]) begin
      d_r <= d_nxt;
      neg3_r <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  logic [FOCAL_W-1:0] rem_r [DIV_STAGES];
  logic [Q_W-1:0]     lo_r  [DIV_STAGES];
  logic [Q_W-1:0]     q_r   [DIV_STAGES];
  axis_flags_t        fl_r  [DIV_STAGES];

  logic [FOCAL_W-1:0] src_rem [DIV_STAGES];
  logic [Q_W-1:0]     src_lo  [DIV_STAGES];
  logic [Q_W-1:0]     src_q   [DIV_STAGES];
  axis_flags_t        src_fl  [DIV_STAGES];

  logic [FOCAL_W-1:0] rem_nxt [DIV_STAGES];
  logic [Q_W-1:0]     lo_nxt  [DIV_STAGES];
  logic [Q_W-1:0]     q_nxt   [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    if (j == 0) begin : g_first
      // The high dividend bits seed the remainder. If they already reach the
      // divisor the quotient needs more than 32 bits and saturates.
      assign src_rem[j] = {7'b0, d_r[DIVD_W-1:Q_W]};
      assign src_lo[j] = d_r[Q_W-1:0];
      assign src_q[j] = '0;
      assign src_fl[j] = '{neg: neg3_r, zero: zero3_r,
                           ovf: ({7'b0, d_r[DIVD_W-1:Q_W]} >= focal)};
    end else begin : g_next
      assign src_rem[j] = rem_r[j-1];
      assign src_lo[j] = lo_r[j-1];
      assign src_q[j] = q_r[j-1];
      assign src_fl[j] = fl_r[j-1];
    end

    always_comb begin
      logic [FOCAL_W-1:0] r;
      logic [FOCAL_W:0]   t;
      logic [Q_W-1:0]     lo;
      logic [Q_W-1:0]     qq;
      r = src_rem[j];
      lo = src_lo[j];
      qq = src_q[j];
      for (int i = 0; i < DIV_STEP; i++) begin
        t = {r, lo[Q_W-1]};
        lo = {lo[Q_W-2:0], 1'b0};
        if (t >= {1'b0, focal}) begin
          t = t - {1'b0, focal};
          qq = {qq[Q_W-2:0], 1'b1};
        end else begin
          qq = {qq[Q_W-2:0], 1'b0};
        end
        r = t[FOCAL_W-1:0];
      end
      rem_nxt[j] = r;
      lo_nxt[j] = lo;
      q_nxt[j] = qq;
    end

    always_ff @(posedge clk) begin
      if (stage_en[ST_DIV0+j]) begin
        rem_r[j] <= rem_nxt[j];
        lo_r[j] <= lo_nxt[j];
        q_r[j] <= q_nxt[j];
        fl_r[j] <= src_fl[j];
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];
  assign flags = fl_r[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/dpbp_checker.sv
// Port-level checks for the back-projection core, bound to the top level.
// Depends on dpbp_pkg for the payload types.
`default_nettype none

module dpbp_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input dpbp_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input dpbp_pkg::out_item_t out_data
);
  import dpbp_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Zero depth is dropped, so no point ever has a zero z.
  a_no_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.point_z != '0))
    else $error("point with zero depth emitted");

  // Color bytes are cleared whenever color is not flagged valid.
  a_color_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.color_valid) |->
      (out_data.point_blue == '0 && out_data.point_green == '0 &&
       out_data.point_red == '0))
    else $error("color bytes set without valid color");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A stalled request stays on the input unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled request changed");

endmodule

bind depth_pixel_back_projection_core dpbp_checker u_dpbp_checker (.*);

`default_nettype wire
